// ----- sv/olist_pkg.sv -----
package olist_pkg;

    // default sizes
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths at the ports
    localparam int CMD_W    = 2;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_ERASE   = 2'd1,
        CMD_FIND    = 2'd2,
        CMD_REPLACE = 2'd3
    } t_cmd;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // per-cycle operation broadcast to every cell
    typedef struct packed {
        logic sample;   // capture compare result
        logic ins;      // insert that passed its checks
        logic era;      // erase that passed its checks
        logic rep;      // replace with a match
    } t_cell_ctrl;

endpackage

// ----- sv/ordered_list_insert_erase_find.sv -----
// An accepted command passes through the compare and apply states before its result is
// registered; apply waits while an older result still waits unclaimed at the output.
// No new command is taken until the current one is applied: each runs the registered
// compare in every cell, then the lowest-match pick and the shift of the cell chain.
// A waiting result sits in the output register while the next command is taken.
// Reset (synchronous, active low) empties the list and clears the handshakes;
// entry contents stay undefined until written.
module ordered_list_insert_erase_find #(
    parameter int DEPTH      = olist_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = olist_pkg::DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [olist_pkg::CMD_W-1:0]    i_command,
    input  logic [olist_pkg::POS_W-1:0]    i_position,
    input  logic [olist_pkg::VAL_W-1:0]    i_value,
    input  logic [olist_pkg::VAL_W-1:0]    i_new_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [olist_pkg::STATUS_W-1:0] o_status,
    output logic [olist_pkg::IDX_W-1:0]    o_found_index,
    output logic [olist_pkg::CNT_W-1:0]    o_entry_count
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(DEPTH);
    localparam int POS_W = olist_pkg::POS_W;
    localparam int CMPW  = (CW > POS_W) ? CW : POS_W;
    localparam int VW    = olist_pkg::VAL_W;
    localparam int IXW   = olist_pkg::IDX_W;
    localparam int CNW   = olist_pkg::CNT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    t_state                r_state;
    olist_pkg::t_cmd       r_cmd;
    logic [CMPW-1:0]       r_pos;
    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] r_new_value;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    olist_pkg::t_status    r_status;
    olist_pkg::t_status    n_status;
    logic [IXW-1:0]        r_found_index;
    logic [CNW-1:0]        r_entry_count;

    logic [DATA_WIDTH+VW-1:0] w_val_ext;
    logic [DATA_WIDTH+VW-1:0] w_nval_ext;
    logic [CMPW+POS_W-1:0]    w_pos_ext;
    logic [CMPW-1:0]          w_count;
    logic [IW+IXW-1:0]        w_idx_ext;
    logic [CW+CNW-1:0]        w_cnt_ext;
    logic [IW-1:0]            n_idx;

    logic                  w_in_acc;
    logic                  w_stall;
    logic                  w_go;
    logic                  w_ok;
    olist_pkg::t_cell_ctrl w_ctrl;

    logic [DATA_WIDTH-1:0] w_entry [DEPTH];
    logic [DEPTH-1:0]      w_match;
    logic [DEPTH-1:0]      w_first;
    logic [IW-1:0]         w_index;
    logic                  w_hit;

    // input handshake and fields widened to internal sizes
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_val_ext  = {{DATA_WIDTH{1'b0}}, i_value};
    assign w_nval_ext = {{DATA_WIDTH{1'b0}}, i_new_value};
    assign w_pos_ext  = {{CMPW{1'b0}}, i_position};
    assign w_count    = CMPW'(r_count);

    // apply waits while an older result is still unclaimed
    assign w_stall = r_out_valid && !i_out_ready;
    assign w_go    = (r_state == S_APPLY) && !w_stall;

    // command checks and result fields
    always_comb begin
        n_status = olist_pkg::ST_OK;
        n_count  = r_count;
        n_idx    = '0;
        case (r_cmd)
            olist_pkg::CMD_INSERT: begin
                if (w_count >= CMPW'(DEPTH)) begin
                    n_status = olist_pkg::ST_FULL;
                end else if (r_pos > w_count) begin
                    n_status = olist_pkg::ST_RANGE;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            olist_pkg::CMD_ERASE: begin
                if (r_pos >= w_count) begin
                    n_status = olist_pkg::ST_RANGE;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            olist_pkg::CMD_FIND, olist_pkg::CMD_REPLACE: begin
                if (w_hit) begin
                    n_idx = w_index;
                end else begin
                    n_status = olist_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                n_status = olist_pkg::ST_OK;
            end
        endcase
    end

    assign w_ok      = (n_status == olist_pkg::ST_OK);
    assign w_idx_ext = {{IXW{1'b0}}, n_idx};
    assign w_cnt_ext = {{CNW{1'b0}}, n_count};

    // operation broadcast to the chain
    always_comb begin
        w_ctrl.sample = (r_state == S_CMP);
        w_ctrl.ins    = w_go && w_ok && (r_cmd == olist_pkg::CMD_INSERT);
        w_ctrl.era    = w_go && w_ok && (r_cmd == olist_pkg::CMD_ERASE);
        w_ctrl.rep    = w_go && w_ok && (r_cmd == olist_pkg::CMD_REPLACE);
    end

    // chain of cells, each talking to its neighbors
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_lo
            assign w_left = r_value;
        end else begin : g_lo
            assign w_left = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_hi
            assign w_right = '0;
        end else begin : g_hi
            assign w_right = w_entry[g+1];
        end

        olist_cell #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (g),
            .CMPW       (CMPW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_pos       (r_pos),
            .i_count     (w_count),
            .i_value     (r_value),
            .i_new_value (r_new_value),
            .i_left      (w_left),
            .i_right     (w_right),
            .i_first     (w_first[g]),
            .o_entry     (w_entry[g]),
            .o_match     (w_match[g])
        );
    end

    // lowest matching cell
    olist_first #(
        .DEPTH (DEPTH)
    ) u_first (
        .i_match (w_match),
        .o_first (w_first),
        .o_index (w_index),
        .o_hit   (w_hit)
    );

    // command capture, sequencing, count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (w_go) begin
                        r_state <= S_IDLE;
                        r_count <= n_count;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (w_in_acc) begin
            r_cmd       <= olist_pkg::t_cmd'(i_command);
            r_pos       <= w_pos_ext[CMPW-1:0];
            r_value     <= w_val_ext[DATA_WIDTH-1:0];
            r_new_value <= w_nval_ext[DATA_WIDTH-1:0];
        end
        if (w_go) begin
            r_status      <= n_status;
            r_found_index <= w_idx_ext[IXW-1:0];
            r_entry_count <= w_cnt_ext[CNW-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_index = r_found_index;
    assign o_entry_count = r_entry_count;

endmodule

// ----- sv/olist_cell.sv -----
module olist_cell #(
    parameter int DEPTH      = olist_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = olist_pkg::DATA_WIDTH_DEF,
    parameter int INDEX      = 0,
    parameter int CMPW       = olist_pkg::POS_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  olist_pkg::t_cell_ctrl  i_ctrl,
    input  logic [CMPW-1:0]        i_pos,
    input  logic [CMPW-1:0]        i_count,
    input  logic [DATA_WIDTH-1:0]  i_value,
    input  logic [DATA_WIDTH-1:0]  i_new_value,
    input  logic [DATA_WIDTH-1:0]  i_left,
    input  logic [DATA_WIDTH-1:0]  i_right,
    input  logic                   i_first,
    output logic [DATA_WIDTH-1:0]  o_entry,
    output logic                   o_match
);

    localparam logic [CMPW-1:0] MY_IDX = CMPW'(INDEX);

    logic [DATA_WIDTH-1:0] r_entry;
    logic [DATA_WIDTH-1:0] n_entry;
    logic                  r_match;
    logic                  n_match;

    // next entry: shift from a neighbor, load, or overwrite
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (MY_IDX == i_pos) begin
                n_entry = i_value;
            end else if (MY_IDX > i_pos && MY_IDX <= i_count) begin
                n_entry = i_left;
            end
        end else if (i_ctrl.era) begin
            if (MY_IDX >= i_pos && (MY_IDX + CMPW'(1)) < i_count) begin
                n_entry = i_right;
            end
        end else if (i_ctrl.rep && i_first) begin
            n_entry = i_new_value;
        end
    end

    // compare only live entries
    assign n_match = (r_entry == i_value) && (MY_IDX < i_count);

    // entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // registered compare result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctrl.sample) begin
            r_match <= n_match;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

// ----- sv/olist_first.sv -----
module olist_first #(
    parameter int DEPTH = olist_pkg::DEPTH_DEF
) (
    input  logic [DEPTH-1:0]         i_match,
    output logic [DEPTH-1:0]         o_first,
    output logic [$clog2(DEPTH)-1:0] o_index,
    output logic                     o_hit
);

    localparam int IW = $clog2(DEPTH);

    // isolate lowest set bit
    assign o_first = i_match & (~i_match + DEPTH'(1));
    assign o_hit   = |i_match;

    // one-hot to binary
    always_comb begin
        o_index = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (o_first[i]) begin
                o_index = o_index | IW'(i);
            end
        end
    end

endmodule

// ----- sv/olist_checker.sv -----
module olist_props #(
    parameter int DEPTH = olist_pkg::DEPTH_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [olist_pkg::STATUS_W-1:0] o_status,
    input logic [olist_pkg::IDX_W-1:0]    o_found_index,
    input logic [olist_pkg::CNT_W-1:0]    o_entry_count
);

    localparam logic [olist_pkg::CNT_W-1:0] FULL_CNT = olist_pkg::CNT_W'(DEPTH);

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_found_index) && $stable(o_entry_count))
        else $error("result changed while stalled");

    // an accepted transaction is followed by a valid result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |-> ##3 o_out_valid)
        else $error("result missing after command");

    // a miss reports index zero
    a_miss_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == olist_pkg::ST_NOT_FOUND) |-> o_found_index == '0)
        else $error("nonzero index on miss");

    // a full report means the list holds every slot
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == olist_pkg::ST_FULL) |-> o_entry_count == FULL_CNT)
        else $error("full status with spare slots");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind ordered_list_insert_erase_find olist_props #(
    .DEPTH (DEPTH)
) u_olist_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_found_index (o_found_index),
    .o_entry_count (o_entry_count)
);

// ----- tb/olist_checker.sv -----
// checker for the ordered list: watches both channels, predicts every result
// from its own copy of the list and compares it with what the block returns
module olist_checker
    import olist_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [POS_W-1:0]    i_position,
    input  logic [VAL_W-1:0]    i_value,
    input  logic [VAL_W-1:0]    i_new_value,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [IDX_W-1:0]    i_found_index,
    input  logic [CNT_W-1:0]    i_entry_count,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status             status;
        logic [IDX_W-1:0]    found_index;
        logic [CNT_W-1:0]    entry_count;
    } list_result_t;

    // shadow copy of the list contents and length
    logic [VAL_W-1:0] list_vals [DEPTH];
    int               list_len;

    list_result_t     results_due [$];
    int               fail_total;
    int               checked_total;

    initial begin
        list_len      = 0;
        fail_total    = 0;
        checked_total = 0;
        o_fail_count  = 0;
        o_pending     = 0;
        o_checked     = 0;
    end

    // apply one command to the shadow list and work out its result
    task automatic apply_list_command(
        input  t_cmd             cmd,
        input  logic [POS_W-1:0] pos,
        input  logic [VAL_W-1:0] val,
        input  logic [VAL_W-1:0] nval,
        output list_result_t     res
    );
        int p;
        int hit;
        p   = int'(pos);
        hit = -1;
        res.status      = ST_OK;
        res.found_index = '0;
        case (cmd)
            CMD_INSERT: begin
                // a full list is refused before the position is looked at
                if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (p > list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
                    list_vals[p] = val;
                    list_len++;
                end
            end
            CMD_ERASE: begin
                if (p >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
                    list_len--;
                end
            end
            default: begin
                // find and replace act on the lowest matching index only
                for (int i = 0; i < list_len; i++) begin
                    if (hit < 0 && list_vals[i] == val) hit = i;
                end
                if (hit < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.found_index = hit[IDX_W-1:0];
                    if (cmd == CMD_REPLACE) list_vals[hit] = nval;
                end
            end
        endcase
        res.entry_count = list_len[CNT_W-1:0];
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        list_result_t want;
        list_result_t fresh;
        if (!i_rst_n) begin
            list_len = 0;
            results_due.delete();
        end else begin
            // result transaction against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("result transaction with no command outstanding");
                    fail_total++;
                end else begin
                    want = results_due.pop_front();
                    checked_total++;
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fail_total++;
                    end
                    if (i_found_index !== want.found_index) begin
                        $error("found_index: expected %0d, actual %0d",
                               want.found_index, i_found_index);
                        fail_total++;
                    end
                    if (i_entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, i_entry_count);
                        fail_total++;
                    end
                end
            end
            // command transaction
            if (i_in_valid && i_in_ready) begin
                apply_list_command(t_cmd'(i_command), i_position, i_value, i_new_value, fresh);
                results_due.push_back(fresh);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= results_due.size();
        o_checked    <= checked_total;
    end

endmodule

// ----- tb/tb_ordered_list_insert_erase_find.sv -----
module tb_ordered_list_insert_erase_find;

    import olist_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 12;
    localparam int POOL_SIZE    = 6;

    // receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_CHOKED = 2;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [CMD_W-1:0]    command;
    logic [POS_W-1:0]    position;
    logic [VAL_W-1:0]    value;
    logic [VAL_W-1:0]    new_value;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    found_index;
    logic [CNT_W-1:0]    entry_count;

    int fail_count;
    int pending;
    int checked;

    // stimulus-side bookkeeping
    int               list_fill;
    int               burst_left;
    int               cmd_sent [4];
    int               full_refusals;
    int               times_full;
    int               cycle_count;
    logic [VAL_W-1:0] val_pool [POOL_SIZE];

    ordered_list_insert_erase_find #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_command     (command),
        .i_position    (position),
        .i_value       (value),
        .i_new_value   (new_value),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (status),
        .o_found_index (found_index),
        .o_entry_count (entry_count)
    );

    olist_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_command     (command),
        .i_position    (position),
        .i_value       (value),
        .i_new_value   (new_value),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (status),
        .i_found_index (found_index),
        .i_entry_count (entry_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    // receiver stalls on a pattern of its own
    initial begin
        int rx_mode;
        int rx_left;
        rx_mode   = RX_OPEN;
        rx_left   = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_left == 0) begin
                rx_mode = $urandom_range(RX_CHOKED, RX_OPEN);
                rx_left = $urandom_range(60, 8);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN: out_ready <= 1'b1;
                RX_COIN: out_ready <= 1'($urandom_range(1, 0));
                default: out_ready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    // one command transaction, then the sender's burst pacing
    task automatic send_command(
        input t_cmd             cmd,
        input logic [POS_W-1:0] pos,
        input logic [VAL_W-1:0] val,
        input logic [VAL_W-1:0] nval
    );
        int gap;
        in_valid  <= 1'b1;
        command   <= cmd;
        position  <= pos;
        value     <= val;
        new_value <= nval;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        cmd_sent[cmd]++;
        // keep track of the length to shape later commands
        if (cmd == CMD_INSERT) begin
            if (list_fill >= DEPTH) begin
                full_refusals++;
            end else if (int'(pos) <= list_fill) begin
                list_fill++;
                if (list_fill == DEPTH) times_full++;
            end
        end else if (cmd == CMD_ERASE && int'(pos) < list_fill) begin
            list_fill--;
        end
        @(negedge clk);
        if (burst_left == 0) begin
            case ($urandom_range(7, 0))
                0, 1:    gap = 0;
                7:       gap = $urandom_range(20, 7);
                default: gap = $urandom_range(6, 1);
            endcase
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(24, 1);
        end else begin
            burst_left--;
        end
    endtask

    // stimulus and verdict
    initial begin
        t_cmd             cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        logic [VAL_W-1:0] nval;
        bit               filling;
        int               pick;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        command       = CMD_INSERT;
        position      = '0;
        value         = '0;
        new_value     = '0;
        list_fill     = 0;
        burst_left    = 0;
        full_refusals = 0;
        times_full    = 0;
        foreach (cmd_sent[i]) cmd_sent[i] = 0;
        val_pool[0] = '0;
        val_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) val_pool[i] = $urandom;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty list: erase, find and insert past the count
        send_command(CMD_ERASE, 5'd0, '0, '0);
        send_command(CMD_FIND, 5'd0, '0, '0);
        send_command(CMD_INSERT, 5'd1, '1, '0);

        // fill to depth at the front, the end and the middle, with duplicates
        for (int k = 0; k < DEPTH; k++) begin
            case (k % 3)
                0:       pos = '0;
                1:       pos = k[POS_W-1:0];
                default: pos = k[POS_W-1:0] / 2;
            endcase
            if (k == 0)          val = '0;
            else if (k % 5 == 1) val = '1;
            else                 val = $urandom;
            send_command(CMD_INSERT, pos, val, '0);
        end

        // full list refuses even an out-of-range position
        send_command(CMD_INSERT, 5'd31, $urandom, '0);
        send_command(CMD_INSERT, 5'd0, $urandom, '0);

        // duplicates: the lowest match is found and replaced
        send_command(CMD_FIND, 5'd0, '1, '0);
        send_command(CMD_REPLACE, 5'd0, '1, 32'h0000_0000);
        send_command(CMD_FIND, 5'd0, '1, '0);

        // erase past the count, the last entry and the first
        send_command(CMD_ERASE, 5'd16, '0, '0);
        send_command(CMD_ERASE, 5'd15, '0, '0);
        send_command(CMD_ERASE, 5'd0, '0, '0);

        // random part: sweep the length between empty and full
        filling = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (list_fill == DEPTH && $urandom_range(3, 0) == 0) filling = 1'b0;
            if (list_fill == 0) filling = 1'b1;
            if ($urandom_range(63, 0) == 0) filling = ~filling;

            pick = $urandom_range(99, 0);
            if (filling) begin
                if (pick < 50)      cmd = CMD_INSERT;
                else if (pick < 65) cmd = CMD_ERASE;
                else if (pick < 85) cmd = CMD_FIND;
                else                cmd = CMD_REPLACE;
            end else begin
                if (pick < 15)      cmd = CMD_INSERT;
                else if (pick < 65) cmd = CMD_ERASE;
                else if (pick < 85) cmd = CMD_FIND;
                else                cmd = CMD_REPLACE;
            end

            // mostly legal positions, some noise over the whole field
            if ($urandom_range(99, 0) < 15)
                pos = POS_W'($urandom_range(31, 0));
            else if (cmd == CMD_ERASE && list_fill > 0)
                pos = POS_W'($urandom_range(list_fill - 1, 0));
            else
                pos = POS_W'($urandom_range(list_fill, 0));

            // values from a small pool so finds and replaces hit
            if ($urandom_range(9, 0) < 7) val = val_pool[$urandom_range(POOL_SIZE - 1, 0)];
            else                          val = $urandom;
            if ($urandom_range(1, 0) == 0) nval = val_pool[$urandom_range(POOL_SIZE - 1, 0)];
            else                           nval = $urandom;

            send_command(cmd, pos, val, nval);
        end

        // wait for the remaining results
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d commands (%0d insert, %0d erase, %0d find, %0d replace)",
                 cmd_sent[CMD_INSERT] + cmd_sent[CMD_ERASE] + cmd_sent[CMD_FIND]
                 + cmd_sent[CMD_REPLACE], cmd_sent[CMD_INSERT], cmd_sent[CMD_ERASE],
                 cmd_sent[CMD_FIND], cmd_sent[CMD_REPLACE]);
        $display("%0d results checked, list reached full depth %0d times, %0d inserts refused",
                 checked, times_full, full_refusals);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
